@@ hdl/can_rx_ping_pong_buffer_core_macros.svh @@
// Assertion macros for the CAN receive ping-pong buffer
`ifndef CAN_RX_PING_PONG_BUFFER_CORE_MACROS_SVH
`define CAN_RX_PING_PONG_BUFFER_CORE_MACROS_SVH
`ifndef SYNTH
`define CRPP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRPP_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CRPP_CHECK(lbl, prop, msg)
`define CRPP_NEVER(lbl, expr, msg)
`endif
`endif

@@ hdl/crpp_pkg.sv @@
// Shared types, codes and address helper for the CAN receive ping-pong buffer
package crpp_pkg;

  localparam int BANK_DEPTH = 32;
  localparam int CNT_W      = $clog2(BANK_DEPTH + 1);
  localparam int ADDR_W     = $clog2(2 * BANK_DEPTH);

  localparam int CMD_W   = 2;
  localparam int ID_W    = 11;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = 6;
  localparam int DROP_W  = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OLDEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BY_ID  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROP = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] frame_bytes;
    logic              batch_end;
    logic [ID_W-1:0]   wanted_id;
  } crpp_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    out_id;
    logic [LEN_W-1:0]   out_length;
    logic [DATA_W-1:0]  out_bytes;
    logic [LEVEL_W-1:0] ready_level;
    logic               wake;
    logic [DROP_W-1:0]  dropped_total;
  } crpp_out_t;

  typedef struct packed {
    logic [LEN_W-1:0]  frame_length;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] frame_bytes;
  } crpp_entry_t;

  localparam int ENTRY_W = $bits(crpp_entry_t);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    crpp_entry_t       wdata;
    logic [ADDR_W-1:0] raddr;
  } crpp_mem_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_OUT
  } crpp_state_t;

  function automatic logic [ADDR_W-1:0] ram_addr(input logic bank,
                                                 input logic [CNT_W-1:0] idx);
    return ADDR_W'(idx) + (bank ? ADDR_W'(BANK_DEPTH) : ADDR_W'(0));
  endfunction

endpackage

@@ hdl/crpp_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module crpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/crpp_seq.sv @@
// Sequencer: bank bookkeeping, search and compaction walk, result register
`include "can_rx_ping_pong_buffer_core_macros.svh"
module crpp_seq
  import crpp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  crpp_in_t      in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output crpp_out_t     out_item,
  output crpp_mem_req_t mem_req,
  input  crpp_entry_t   rd_entry
);

  crpp_state_t       state_r, state_nxt;
  logic              active_bank_r, active_bank_nxt;
  logic [CNT_W-1:0]  active_fill_r, active_fill_nxt;
  logic [CNT_W-1:0]  ready_fill_r, ready_fill_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic              notify_r, notify_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ID_W-1:0]   want_r, want_nxt;
  crpp_out_t         res_r, res_nxt;
  crpp_out_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic             ready_bank;
  logic             push_full;
  logic [CNT_W-1:0] push_fill;
  logic             issue;
  logic             match;
  logic             out_free;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_item   = out_r;
  assign ready_bank = ~active_bank_r;
  assign push_full  = (active_fill_r == CNT_W'(BANK_DEPTH));
  assign push_fill  = push_full ? active_fill_r : active_fill_r + 1'b1;
  assign issue      = (rd_idx_r < ready_fill_r);
  assign match      = pend_r && ((cmd_r == CMD_OLDEST) || (rd_entry.frame_id == want_r));
  assign out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      active_bank_r <= 1'b0;
      active_fill_r <= '0;
      ready_fill_r  <= '0;
      drop_r        <= '0;
      notify_r      <= 1'b0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      active_bank_r <= active_bank_nxt;
      active_fill_r <= active_fill_nxt;
      ready_fill_r  <= ready_fill_nxt;
      drop_r        <= drop_nxt;
      notify_r      <= notify_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    cmd_r    <= cmd_nxt;
    want_r   <= want_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    active_bank_nxt = active_bank_r;
    active_fill_nxt = active_fill_r;
    ready_fill_nxt  = ready_fill_r;
    drop_nxt        = drop_r;
    notify_nxt      = cfg_wr_en ? cfg_wr_data : notify_r;
    rd_idx_nxt      = rd_idx_r;
    wr_idx_nxt      = wr_idx_r;
    pend_nxt        = pend_r;
    cmd_nxt         = cmd_r;
    want_nxt        = want_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && out_stall;
    mem_req.we      = 1'b0;
    mem_req.waddr   = ram_addr(ready_bank, wr_idx_r);
    mem_req.wdata   = rd_entry;
    mem_req.raddr   = ram_addr(ready_bank, rd_idx_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt        = '0;
          res_nxt.status = ST_NONE;
          cmd_nxt        = in_item.command;
          want_nxt       = in_item.wanted_id;
          rd_idx_nxt     = '0;
          pend_nxt       = 1'b0;
          state_nxt      = S_OUT;
          case (in_item.command)
            CMD_PUSH: begin
              if (push_full) begin
                drop_nxt       = drop_r + 1'b1;
                res_nxt.status = ST_DROP;
              end else begin
                mem_req.we                 = 1'b1;
                mem_req.waddr              = ram_addr(active_bank_r, active_fill_r);
                mem_req.wdata.frame_id     = in_item.frame_id;
                mem_req.wdata.frame_length = in_item.frame_length;
                mem_req.wdata.frame_bytes  = in_item.frame_bytes;
                res_nxt.status             = ST_OK;
              end
              active_fill_nxt = push_fill;
              if (in_item.batch_end) begin
                if (ready_fill_r == '0 && push_fill != '0) begin
                  ready_fill_nxt  = push_fill;
                  active_bank_nxt = ~active_bank_r;
                  active_fill_nxt = '0;
                  res_nxt.wake    = notify_r;
                end else begin
                  res_nxt.wake    = notify_r && (ready_fill_r != '0);
                end
              end
            end
            CMD_OLDEST, CMD_BY_ID: begin
              if (ready_fill_r == '0 && active_fill_r != '0) begin
                ready_fill_nxt  = active_fill_r;
                active_bank_nxt = ~active_bank_r;
                active_fill_nxt = '0;
                state_nxt       = S_SCAN;
              end else if (ready_fill_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        pend_nxt = issue;
        if (match) begin
          res_nxt.status     = ST_OK;
          res_nxt.out_id     = rd_entry.frame_id;
          res_nxt.out_length = rd_entry.frame_length;
          res_nxt.out_bytes  = rd_entry.frame_bytes;
          wr_idx_nxt         = rd_idx_r - 1'b1;
          state_nxt          = S_SHIFT;
        end else if (pend_r && !issue) begin
          state_nxt = S_OUT;
        end
      end
      S_SHIFT: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        pend_nxt = issue;
        if (pend_r) begin
          mem_req.we = 1'b1;
          wr_idx_nxt = wr_idx_r + 1'b1;
        end else begin
          ready_fill_nxt = ready_fill_r - 1'b1;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_nxt               = res_r;
          out_nxt.ready_level   = LEVEL_W'(ready_fill_r);
          out_nxt.dropped_total = drop_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `CRPP_CHECK(a_active_bound, active_fill_r <= CNT_W'(BANK_DEPTH), "active fill beyond bank")
  `CRPP_CHECK(a_ready_bound, ready_fill_r <= CNT_W'(BANK_DEPTH), "ready fill beyond bank")
  `CRPP_NEVER(a_scan_empty, state_r == S_SCAN && ready_fill_r == '0, "scan of empty bank")
  `CRPP_CHECK(a_shift_inside, state_r == S_SHIFT |-> wr_idx_r < ready_fill_r, "move past fill")

endmodule

@@ hdl/can_rx_ping_pong_buffer_core.sv @@
// Top level of the CAN receive ping-pong buffer
//
// Input transactions carry a command: push a received frame, read the oldest
// ready frame, or read the first ready frame with a given identifier. Every
// transaction yields exactly one result transaction with status, the frame
// read out, the ready level, a wake flag and the wrapping drop count.
// Frames live in one RAM holding both banks; the bank roles swap on publish.
// A push goes from acceptance through the S_OUT state into the output
// register. A read searches the ready bank and, on a hit, compacts it;
// both walks go through the ready bank one entry per cycle over the RAM's
// single read and write port, with registered read data.
// One transaction is worked on at a time; a new one is accepted once the
// previous result sits in the output register, even while it is stalled.
// A stalled result holds until taken; no further result is loaded meanwhile.
// The configuration write sets notify_enable; it is registered and applies to pushes accepted after it.
// Synchronous reset empties both banks, clears the drop count and
// notify_enable; RAM contents need no clearing.
module can_rx_ping_pong_buffer_core
  import crpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  crpp_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output crpp_out_t out_item
);

  crpp_mem_req_t      mem_req;
  logic [ENTRY_W-1:0] ram_rdata;

  crpp_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .mem_req     (mem_req),
    .rd_entry    (crpp_entry_t'(ram_rdata))
  );

  crpp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 * BANK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
